@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the word generator RTL.
// Holds implication helpers that compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(label, clk, rstn, ante, cons)
`define ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/mtwg_pkg.sv @@
// Package for the MT19937 word generator: constants, codes, structs, helpers.
// No dependencies.
package mtwg_pkg;

    localparam int unsigned TWIST_OFFSET = 397;

    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] HI_BIT       = 32'h8000_0000;
    localparam logic [31:0] LO_BITS      = 32'h7FFF_FFFF;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    // Request function codes; the unused code behaves as a raw draw.
    localparam logic [1:0] FUNC_RAW  = 2'd0;
    localparam logic [1:0] FUNC_MOD  = 2'd1;
    localparam logic [1:0] FUNC_SPAN = 2'd2;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] remainder;
    } rem_rsp_t;

    // One step of the recurrence: oldest word, its neighbor and the far tap.
    function automatic logic [31:0] twist_word(input logic [31:0] w_cur,
                                               input logic [31:0] w_nxt,
                                               input logic [31:0] w_far);
        logic [31:0] mix;
        mix = (w_cur & HI_BIT) | (w_nxt & LO_BITS);
        return w_far ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'd0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

endpackage

@@ hw/rtl/mtwg_if.sv @@
// Handshake interfaces for the word generator request and response channels.
// No dependencies.
interface mtwg_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;

    modport source (output valid, func, lower_bound, upper_bound, input ready);
    modport sink   (input valid, func, lower_bound, upper_bound, output ready);
endinterface

interface mtwg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink   (input valid, value, range_error, output ready);
endinterface

@@ hw/rtl/mtwg_cell.sv @@
// One state word of the twister shift chain.
// No dependencies.
module mtwg_cell (
    input  logic        clk,
    input  logic        shift_en,
    input  logic [31:0] d,
    output logic [31:0] q
);

    logic [31:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

@@ hw/rtl/mtwg_rem.sv @@
// Restoring remainder unit, one quotient bit per cycle.
// Depends on mtwg_pkg (rem_req_t, rem_rsp_t).
module mtwg_rem
    import mtwg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    localparam int unsigned STEPS = 32;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      rem_reg;
    logic [31:0]      dvd_reg;
    logic [31:0]      dvs_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] rem_step;

    // Bring down the next dividend bit and subtract when it fits.
    assign trial    = {rem_reg, dvd_reg[31]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_step = diff[32] ? trial[31:0] : diff[31:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ hw/rtl/mt19937_word_generator.sv @@
// MT19937 word generator top level; depends on mtwg_pkg, mtwg_if, mtwg_cell,
// mtwg_rem and assert_macros.svh.
// Usage: a request word on req (func, lower_bound, upper_bound) draws one
// tempered 32-bit word; rsp returns value and range_error. func 0 (and 3)
// gives the raw word, 1 the word mod (upper_bound+1), 2 lower_bound plus the
// word mod (upper_bound-lower_bound), truncating remainder of the signed word.
// A divisor of zero or below returns 0 with range_error set; a word is spent.
// The state lives in a chain of STATE_WORDS cells; each draw shifts it by one,
// the new tail word being the recurrence on the head, its neighbor and tap 397.
// From accept to rsp.valid a raw word or a range error passes ST_STEP,
// ST_TEMPER, ST_PREP and ST_FIN; a reduced word also waits in ST_DIV for
// the remainder unit. One request is in flight at a time.
// The first request after reset or after a cfg_wr_en write first seeds the
// chain, one word a cycle: the seed itself, then the seeding multiplier.
// Reset clears control and output registers and loads seed 5489; no more.
// A stalled receiver holds the result in the output register; the next request
// is still taken and waits at its end until the register frees up.
`include "assert_macros.svh"
module mt19937_word_generator
    import mtwg_pkg::*;
#(
    parameter int unsigned STATE_WORDS = 624
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    mtwg_req_if.sink    req,
    mtwg_rsp_if.source  rsp
);

    localparam int unsigned CNT_W = $clog2(STATE_WORDS);
    localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(STATE_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_TEMPER,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic             seeded_reg, seeded_next;
    logic [CNT_W-1:0] seed_cnt_reg, seed_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      value_reg, value_next;
    logic             range_error_reg, range_error_next;
    logic [31:0]      seed_value_reg;

    // Request payload and per-draw working registers.
    logic [1:0]  func_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic [31:0] raw_reg;
    logic [31:0] word_reg;
    logic        err_pend_reg;

    logic [31:0] cell_q [STATE_WORDS];
    logic [31:0] tail_d;
    logic        shift_en;

    logic [31:0] twist_new;
    logic [31:0] init_mix;
    logic [31:0] init_word;

    logic        reduce_mode;
    logic [32:0] div_wide;
    logic        div_bad;
    logic [31:0] word_mag;
    logic [31:0] rem_signed;
    logic [31:0] reduced;
    logic [31:0] result;

    rem_req_t rem_req;
    rem_rsp_t rem_rsp;
    logic     rem_start;

    // State chain: cell 0 is the oldest word, the tail takes the new one.
    for (genvar g = 0; g < STATE_WORDS; g++)
    begin : g_chain
        if (g == STATE_WORDS - 1)
        begin : g_tail
            mtwg_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tail_d),
                .q        (cell_q[g])
            );
        end
        else
        begin : g_body
            mtwg_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[g+1]),
                .q        (cell_q[g])
            );
        end
    end

    // Next word of the sequence from the head, its neighbor and the far tap.
    assign twist_new = twist_word(cell_q[0], cell_q[1], cell_q[TWIST_OFFSET]);

    // Seeding recurrence on the word that was last shifted into the tail.
    assign init_mix  = cell_q[STATE_WORDS-1] ^ (cell_q[STATE_WORDS-1] >> 30);
    assign init_word = (INIT_MULT * init_mix) + 32'(seed_cnt_reg);

    // Divisor, computed one bit wider so that it never wraps.
    assign reduce_mode = (func_reg == FUNC_MOD) || (func_reg == FUNC_SPAN);
    always_comb
    begin
        if (func_reg == FUNC_MOD)
        begin
            div_wide = {hi_reg[31], hi_reg} + 33'd1;
        end
        else
        begin
            div_wide = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
        end
    end
    assign div_bad = div_wide[32] || (div_wide == 33'd0);

    // Divide the magnitude, then give the remainder the sign of the word.
    assign word_mag   = word_reg[31] ? (~word_reg + 32'd1) : word_reg;
    assign rem_signed = word_reg[31] ? (~rem_rsp.remainder + 32'd1) : rem_rsp.remainder;
    assign reduced    = rem_signed + ((func_reg == FUNC_SPAN) ? lo_reg : 32'd0);

    always_comb
    begin
        if (!reduce_mode)
        begin
            result = word_reg;
        end
        else if (err_pend_reg)
        begin
            result = 32'd0;
        end
        else
        begin
            result = reduced;
        end
    end

    assign rem_req.start    = rem_start;
    assign rem_req.dividend = word_mag;
    assign rem_req.divisor  = div_wide[31:0];

    mtwg_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        seeded_next      = seeded_reg;
        seed_cnt_next    = seed_cnt_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        value_next       = value_reg;
        range_error_next = range_error_reg;
        shift_en         = 1'b0;
        tail_d           = twist_new;
        rem_start        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    seed_cnt_next = '0;
                    state_next    = seeded_reg ? ST_STEP : ST_SEED;
                end
            end
            ST_SEED:
            begin
                // Fill the chain: the seed itself first, then the recurrence.
                shift_en      = 1'b1;
                tail_d        = (seed_cnt_reg == '0) ? seed_value_reg : init_word;
                seed_cnt_next = seed_cnt_reg + 1'b1;
                if (seed_cnt_reg == SEED_LAST)
                begin
                    seeded_next = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // Advance the chain by one word.
                shift_en   = 1'b1;
                state_next = ST_TEMPER;
            end
            ST_TEMPER:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (reduce_mode && !div_bad)
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (rem_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hold here while the previous word is still unclaimed.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    value_next       = result;
                    range_error_next = err_pend_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en)
        begin
            seeded_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seeded_reg      <= 1'b0;
            seed_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
            value_reg       <= '0;
            range_error_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            seeded_reg      <= seeded_next;
            seed_cnt_reg    <= seed_cnt_next;
            out_valid_reg   <= out_valid_next;
            value_reg       <= value_next;
            range_error_reg <= range_error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg <= SEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            seed_value_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            lo_reg   <= req.lower_bound;
            hi_reg   <= req.upper_bound;
        end
        if (state_reg == ST_STEP)
        begin
            raw_reg <= twist_new;
        end
        if (state_reg == ST_TEMPER)
        begin
            word_reg <= temper(raw_reg);
        end
        if (state_reg == ST_PREP)
        begin
            err_pend_reg <= reduce_mode && div_bad;
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.value       = value_reg;
    assign rsp.range_error = range_error_reg;

    `ASSERT_IMP(a_err_gives_zero, clk, rst_n, rsp.valid && rsp.range_error, rsp.value == 32'd0)
    `ASSERT_IMP(a_rem_done_in_div, clk, rst_n, rem_rsp.done, state_reg == ST_DIV)
    `ASSERT_NXT(a_unseeded_seeds, clk, rst_n, req.valid && req.ready && !seeded_reg, state_reg == ST_SEED)

endmodule
